FILE: hdl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and arithmetic for the l1 smoother diagonal
// Item layouts, kind and register codes, sequencer states and the
// saturating Q16.16 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ENT_W = VAL_W + 1;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_OFFDIAG = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic REG_MASK_ENABLE = 1'b0;

  localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
    logic                    is_boundary;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] sum_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_COLWR,
    ST_READ
  } state_e;

  function automatic logic [VAL_W-2:0] sat_abs(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] n;
    n = v[VAL_W-1] ? (~v + 32'd1) : v;
    return n[VAL_W-1] ? Q_MAX[VAL_W-2:0] : n[VAL_W-2:0];
  endfunction

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] s,
                                              input logic [VAL_W-2:0] m);
    logic [VAL_W:0] t;
    t = {s[VAL_W-1], s} + {2'b00, m};
    return (!t[VAL_W] && t[VAL_W-1]) ? Q_MAX : t[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lsd_ram.sv
// ----------------------------------------------------------------------------
// lsd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/l1_smoother_diagonal.sv
// ----------------------------------------------------------------------------
// l1_smoother_diagonal: l1-Jacobi smoother diagonal builder
// Accumulates saturated |a_ij| into per-entry Q16.16 sums held in one RAM.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in channel (valid/stall); read items produce one
// transfer on the out channel. mask_enable sits at APB address 0 (reset 1)
// and must be written only while the block is idle; the block itself does
// not enforce this. Each RAM word holds {boundary flag, sum}. Steps per item,
// ordered by the single RAM write port and registered read data:
//   load            written at acceptance
//   off-diagonal    read row, read column, write row, write column;
//                   reads only when masked; dropped if an index >= DIM_MAX
//   read            read issued at acceptance, result then registered
//   unused kind     accepted and dropped
// One item is in flight at a time. A finished result waits in the output
// register; loads and off-diagonal items keep flowing while the receiver
// stalls, and a read holds in place until the output register frees up.
// Reset empties the output register, returns the sequencer to idle and sets
// mask_enable; RAM contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module l1_smoother_diagonal #(
  parameter int unsigned DIM_MAX = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lsd_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lsd_pkg::out_item_t     out_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int unsigned AW = $clog2(DIM_MAX);

  lsd_pkg::state_e state_q, state_d;
  lsd_pkg::in_item_t item_q, item_d;
  logic [lsd_pkg::VAL_W-2:0] mag_q, mag_d;
  logic [lsd_pkg::ENT_W-1:0] ent_q, ent_d;
  logic out_valid_q, out_valid_d;
  lsd_pkg::out_item_t out_q, out_d;
  logic mask_q;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [lsd_pkg::ENT_W-1:0] ram_wdata, ram_rdata;

  logic in_fire, in_row_ok, in_col_ok, row_ok, cfg_write;
  logic [lsd_pkg::VAL_W-1:0] row_new;

  assign in_row_ok = 32'(in_item_i.row_index) < 32'(DIM_MAX);
  assign in_col_ok = 32'(in_item_i.col_index) < 32'(DIM_MAX);
  assign row_ok    = 32'(item_q.row_index) < 32'(DIM_MAX);
  assign in_stall_o = (state_q != lsd_pkg::ST_IDLE);
  assign in_fire   = in_valid_i && !in_stall_o;
  assign row_new   = lsd_pkg::sat_add(ent_q[lsd_pkg::VAL_W-1:0], mag_q);

  lsd_ram #(
    .WIDTH (lsd_pkg::ENT_W),
    .DEPTH (DIM_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    mag_d       = mag_q;
    ent_d       = ent_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = AW'(item_q.row_index);
    ram_raddr   = AW'(item_q.row_index);
    ram_wdata   = ent_q;

    unique case (state_q)
      lsd_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_d    = in_item_i;
          mag_d     = lsd_pkg::sat_abs(in_item_i.value);
          ram_waddr = AW'(in_item_i.row_index);
          ram_raddr = AW'(in_item_i.row_index);
          ram_wdata = {in_item_i.is_boundary, in_item_i.value};
          unique case (in_item_i.kind)
            lsd_pkg::KIND_LOAD: begin
              ram_we = in_row_ok;
            end
            lsd_pkg::KIND_OFFDIAG: begin
              if (in_row_ok && in_col_ok) begin
                ram_re  = 1'b1;
                state_d = lsd_pkg::ST_ROW;
              end
            end
            lsd_pkg::KIND_READ: begin
              ram_re  = 1'b1;
              state_d = lsd_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      lsd_pkg::ST_ROW: begin
        ent_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = AW'(item_q.col_index);
        state_d   = lsd_pkg::ST_COL;
      end
      lsd_pkg::ST_COL: begin
        if (mask_q && (ent_q[lsd_pkg::VAL_W] || ram_rdata[lsd_pkg::VAL_W])) begin
          state_d = lsd_pkg::ST_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {ent_q[lsd_pkg::VAL_W], row_new};
          ent_d     = (item_q.row_index == item_q.col_index) ?
                      {ent_q[lsd_pkg::VAL_W], row_new} : ram_rdata;
          state_d   = lsd_pkg::ST_COLWR;
        end
      end
      lsd_pkg::ST_COLWR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(item_q.col_index);
        ram_wdata = {ent_q[lsd_pkg::VAL_W], row_new};
        state_d   = lsd_pkg::ST_IDLE;
      end
      lsd_pkg::ST_READ: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.out_index = item_q.row_index;
          out_d.sum_value = (row_ok && !(mask_q && ram_rdata[lsd_pkg::VAL_W])) ?
                            ram_rdata[lsd_pkg::VAL_W-1:0] : '0;
          state_d         = lsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    mag_q  <= mag_d;
    ent_q  <= ent_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 1'b1;
    end else if (cfg_write && (paddr[2] == lsd_pkg::REG_MASK_ENABLE)) begin
      mask_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lsd_pkg::REG_MASK_ENABLE) begin
      prdata = {31'd0, mask_q};
    end
  end

  a_result_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lsd_pkg::ST_READ))
    else $error("result appeared without a read");

  a_colwr_after_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lsd_pkg::ST_COLWR |-> $past(state_q == lsd_pkg::ST_COL))
    else $error("column write-back out of sequence");

  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("read and write to one RAM word in the same cycle");

endmodule

`default_nettype wire
